// ===== hw/rtl/sbca_pkg.sv =====
package sbca_pkg;

   // largest sprite edge in pixels
   localparam int MAX_DIM = 4096;

   // counter width holds 0 .. MAX_DIM-1
   localparam int CNT_W = $clog2(MAX_DIM);
   // sprite size as used, 1 .. MAX_DIM
   localparam int DIM_W = CNT_W + 1;

   // fixed register and field widths
   localparam int CFG_W   = 13;
   localparam int PITCH_W = 15;
   localparam int ADDR_W  = 26;
   localparam int PIX_W   = 32;
   localparam int IDX_W   = 3;

   // signed destination position, wide enough for start plus counter
   localparam int POS_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 2;
   localparam int POSU_W = POS_W - 1;
   localparam int MUL_W  = POSU_W + PITCH_W;

   localparam logic [PIX_W-1:0] ALPHA_BITS = 32'hFF00_0000;

   typedef enum logic [IDX_W-1:0] {
      REG_SPRITE_WIDTH  = 3'd0,
      REG_SPRITE_HEIGHT = 3'd1,
      REG_START_X       = 3'd2,
      REG_START_Y       = 3'd3,
      REG_OUT_WIDTH     = 3'd4,
      REG_OUT_HEIGHT    = 3'd5,
      REG_ROW_PITCH     = 3'd6
   } reg_index_type;

   // zero acts as one, oversize acts as MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (int'(d) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(d);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/sprite_blit_clip_alpha_test_top.sv =====
// sprite blitter back end: places, clips and alpha-tests one pixel per beat
// a request beat is registered in the position stage, then in the response register, before it is offered as a response
// throughput: one pixel per cycle sustained while rsp_ready holds, set by the two-register pipeline
// (position stage, then clip/address stage with one 14x15 multiply)
// reset (synchronous, active high): counters cleared, pipeline emptied,
// registers back to width 1, height 1, start 0, clip 0, pitch 4
module sprite_blit_clip_alpha_test_top (
   input  logic                             clock,
   input  logic                             reset,
   // pixel request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sbca_pkg::PIX_W-1:0]       req_pixel,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_write_enable,
   output logic [sbca_pkg::ADDR_W-1:0]      rsp_dest_address,
   output logic [sbca_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic                             rsp_last,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sbca_pkg::IDX_W-1:0]       csr_index,
   input  logic [31:0]                      csr_data
);

   // configuration registers
   logic [sbca_pkg::CFG_W-1:0]          sprite_width_ff;
   logic [sbca_pkg::CFG_W-1:0]          sprite_height_ff;
   logic signed [sbca_pkg::CFG_W-1:0]   start_x_ff;
   logic signed [sbca_pkg::CFG_W-1:0]   start_y_ff;
   logic [sbca_pkg::CFG_W-1:0]          out_width_ff;
   logic [sbca_pkg::CFG_W-1:0]          out_height_ff;
   logic [sbca_pkg::PITCH_W-1:0]        row_pitch_ff;

   // raster counters
   logic [sbca_pkg::CNT_W-1:0]          col_ff, col_in;
   logic [sbca_pkg::CNT_W-1:0]          row_ff, row_in;

   // stage 1: position
   logic                                s1_valid_ff;
   logic [sbca_pkg::PIX_W-1:0]          s1_pixel_ff;
   logic signed [sbca_pkg::POS_W-1:0]   s1_x_ff, s1_x_in;
   logic signed [sbca_pkg::POS_W-1:0]   s1_y_ff, s1_y_in;
   logic                                s1_last_ff, s1_last_in;

   // stage 2: response register
   logic                                rsp_valid_ff;
   logic                                rsp_we_ff, rsp_we_in;
   logic [sbca_pkg::ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [sbca_pkg::PIX_W-1:0]          rsp_pixel_ff;
   logic                                rsp_last_ff;

   logic                                out_adv;
   logic                                req_fire;
   logic [sbca_pkg::DIM_W-1:0]          w_eff, h_eff;
   logic                                col_end, row_end;
   logic [sbca_pkg::POSU_W-1:0]         x_u, y_u;
   logic                                in_clip;
   logic [sbca_pkg::MUL_W-1:0]          mul_full;

   // csr writes are always accepted at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_width_ff  <= sbca_pkg::CFG_W'(1);
         sprite_height_ff <= sbca_pkg::CFG_W'(1);
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         out_width_ff     <= '0;
         out_height_ff    <= '0;
         row_pitch_ff     <= sbca_pkg::PITCH_W'(4);
      end else if (csr_valid) begin
         case (sbca_pkg::reg_index_type'(csr_index))
            sbca_pkg::REG_SPRITE_WIDTH:  sprite_width_ff  <= csr_data[sbca_pkg::CFG_W-1:0];
            sbca_pkg::REG_SPRITE_HEIGHT: sprite_height_ff <= csr_data[sbca_pkg::CFG_W-1:0];
            sbca_pkg::REG_START_X:       start_x_ff       <= csr_data[sbca_pkg::CFG_W-1:0];
            sbca_pkg::REG_START_Y:       start_y_ff       <= csr_data[sbca_pkg::CFG_W-1:0];
            sbca_pkg::REG_OUT_WIDTH:     out_width_ff     <= csr_data[sbca_pkg::CFG_W-1:0];
            sbca_pkg::REG_OUT_HEIGHT:    out_height_ff    <= csr_data[sbca_pkg::CFG_W-1:0];
            sbca_pkg::REG_ROW_PITCH:     row_pitch_ff     <= csr_data[sbca_pkg::PITCH_W-1:0];
            default: ; // index beyond the register list is dropped
         endcase
      end
   end

   // pipeline moves when the response slot is free or being taken
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_adv;
   assign req_fire  = req_valid && req_ready;

   // sprite size as used by the raster walk
   assign w_eff = sbca_pkg::eff_dim(sprite_width_ff);
   assign h_eff = sbca_pkg::eff_dim(sprite_height_ff);

   // wrap test uses >= so a counter left past a shrunken size still wraps
   assign col_end = ({1'b0, col_ff} + sbca_pkg::DIM_W'(1)) >= w_eff;
   assign row_end = ({1'b0, row_ff} + sbca_pkg::DIM_W'(1)) >= h_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + sbca_pkg::CNT_W'(1);
         end else begin
            col_in = col_ff + sbca_pkg::CNT_W'(1);
         end
      end
   end

   // destination position of the incoming pixel
   assign s1_x_in    = sbca_pkg::POS_W'(start_x_ff) + $signed(sbca_pkg::POS_W'(col_ff));
   assign s1_y_in    = sbca_pkg::POS_W'(start_y_ff) + $signed(sbca_pkg::POS_W'(row_ff));
   assign s1_last_in = col_end && row_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff <= req_pixel;
         s1_x_ff     <= s1_x_in;
         s1_y_ff     <= s1_y_in;
         s1_last_ff  <= s1_last_in;
      end
   end

   // clip against the surface, low bits are the position once it is nonnegative
   assign x_u     = s1_x_ff[sbca_pkg::POSU_W-1:0];
   assign y_u     = s1_y_ff[sbca_pkg::POSU_W-1:0];
   assign in_clip = !s1_x_ff[sbca_pkg::POS_W-1] && !s1_y_ff[sbca_pkg::POS_W-1] &&
                    (x_u < sbca_pkg::POSU_W'(out_width_ff)) &&
                    (y_u < sbca_pkg::POSU_W'(out_height_ff));

   // alpha test: fully transparent pixels are not written
   assign rsp_we_in = in_clip && ((s1_pixel_ff & sbca_pkg::ALPHA_BITS) != '0);

   // byte address = y * pitch + 4 * x, wrapping at the address width
   assign mul_full    = sbca_pkg::MUL_W'(y_u) * sbca_pkg::MUL_W'(row_pitch_ff);
   assign rsp_addr_in = rsp_we_in ?
                        (sbca_pkg::ADDR_W'(mul_full) + sbca_pkg::ADDR_W'({x_u, 2'b00})) :
                        '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_valid_ff) begin
         rsp_we_ff    <= rsp_we_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_pixel_ff <= s1_pixel_ff;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_dest_address = rsp_addr_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_last         = rsp_last_ff;

   // a written pixel is never transparent
   a_we_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_we_ff |-> (rsp_pixel_ff[31:24] != 8'd0))
      else $error("write enabled on a transparent pixel");

   // suppressed writes carry a zero address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_we_ff |-> (rsp_addr_ff == '0))
      else $error("nonzero address on a suppressed write");

   // end of a row sends the column back to zero
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && col_end |=> (col_ff == '0))
      else $error("column counter did not wrap");

   // full pipeline with a stalled response holds off new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline is full");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
